/* design/ami_pkg.sv */
// Shared types and constants for the affine 3x4 matrix inverse.
package ami_pkg;

  localparam int ELEM_W = 32;                 // element width
  localparam int ADJ_W  = 64;                 // exact 2x2 minor
  localparam int DET_W  = 98;                 // exact determinant, signed
  localparam int QB     = 33;                 // quotient bits resolved by the divider
  localparam int ACC_W  = 67;                 // translation accumulator
  localparam logic [1:0] ROW_LAST = 2'd2;

  typedef struct packed {
    logic [1:0]                   row;
    logic                         sing;
    logic [2:0][ELEM_W-1:0]       tr;   // a03, a13, a23
  } row_meta_t;

endpackage

/* design/affine_matrix_inverse_top.sv */
// Affine 3x4 matrix inverse: pipelined adjugate, determinant, division and translation.
//
//  channel | signals                               | direction | request
//  --------+---------------------------------------+-----------+-------------------------
//  in      | in_valid in_ready a00..a23            | to block  | one 3x4 matrix
//  out     | out_valid out_ready row_index c0..c3  | from block| one inverse row
//          | singular last_row                     |           |
//
// A new matrix is accepted as the hold register issues the last of its three rows;
// the rows enter the pipeline one row a cycle while the output is not stalled. Each
// row passes 6 register stages of products, minors, determinant and operand set-up,
// 33 restoring divider stages and 4 of rounding and translation. Reset clears only
// valid bits, the busy flag and the row counter. A stalled output freezes the whole
// pipeline in place; nothing is dropped or repeated.
module affine_matrix_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] a00, a01, a02, a03,
  input  logic signed [31:0] a10, a11, a12, a13,
  input  logic signed [31:0] a20, a21, a22, a23,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  row_index,
  output logic signed [31:0] c0, c1, c2, c3,
  output logic        singular,
  output logic        last_row
);

  localparam int EW  = ami_pkg::ELEM_W;
  localparam int AW  = ami_pkg::ADJ_W;
  localparam int DW  = ami_pkg::DET_W;
  localparam int QB  = ami_pkg::QB;
  localparam int CW  = ami_pkg::ACC_W;
  // numerator 2|adj<<2F| + |det| and divisor 2|det|
  localparam int WN  = (2*FRAC_BITS + 67 > DW + 1) ? 2*FRAC_BITS + 67 : DW + 1;

  logic adv;          // whole pipeline advances
  assign adv = !out_valid || out_ready;

  // ---------------- hold register: one matrix, issued row by row
  logic              busy;
  logic [1:0]        rcnt;
  logic signed [EW-1:0] m [12];
  logic              in_fire;

  assign in_ready = !busy || (adv && rcnt == ami_pkg::ROW_LAST);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rcnt <= 2'd0;
    end else if (in_fire) begin
      busy <= 1'b1;
      rcnt <= 2'd0;
    end else if (busy && adv) begin
      rcnt <= rcnt + 2'd1;
      if (rcnt == ami_pkg::ROW_LAST) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m[0] <= a00; m[1] <= a01; m[2]  <= a02; m[3]  <= a03;
      m[4] <= a10; m[5] <= a11; m[6]  <= a12; m[7]  <= a13;
      m[8] <= a20; m[9] <= a21; m[10] <= a22; m[11] <= a23;
    end
  end

  // ---------------- P1: products for the adjugate row and determinant column
  logic signed [EW-1:0] pl [3], pr [3], ml [3], mr [3];
  always_comb begin
    case (rcnt)
      2'd0: begin
        pl[0] = m[5];  pr[0] = m[10]; ml[0] = m[9];  mr[0] = m[6];
        pl[1] = m[9];  pr[1] = m[2];  ml[1] = m[1];  mr[1] = m[10];
        pl[2] = m[1];  pr[2] = m[6];  ml[2] = m[5];  mr[2] = m[2];
      end
      2'd1: begin
        pl[0] = m[8];  pr[0] = m[6];  ml[0] = m[4];  mr[0] = m[10];
        pl[1] = m[0];  pr[1] = m[10]; ml[1] = m[8];  mr[1] = m[2];
        pl[2] = m[4];  pr[2] = m[2];  ml[2] = m[0];  mr[2] = m[6];
      end
      default: begin
        pl[0] = m[4];  pr[0] = m[9];  ml[0] = m[8];  mr[0] = m[5];
        pl[1] = m[8];  pr[1] = m[1];  ml[1] = m[0];  mr[1] = m[9];
        pl[2] = m[0];  pr[2] = m[5];  ml[2] = m[4];  mr[2] = m[1];
      end
    endcase
  end

  logic                 v1;
  ami_pkg::row_meta_t   meta1;
  logic signed [AW-1:0] pp1 [3], mp1 [3], cp1 [3], cm1 [3];
  logic signed [EW-1:0] r01 [3];   // a00, a01, a02

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= busy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        pp1[j] <= AW'(pl[j]) * AW'(pr[j]);
        mp1[j] <= AW'(ml[j]) * AW'(mr[j]);
        r01[j] <= m[j];
      end
      // column 0 of the adjugate, always needed for the determinant
      cp1[0] <= AW'(m[5]) * AW'(m[10]);  cm1[0] <= AW'(m[9]) * AW'(m[6]);
      cp1[1] <= AW'(m[8]) * AW'(m[6]);   cm1[1] <= AW'(m[4]) * AW'(m[10]);
      cp1[2] <= AW'(m[4]) * AW'(m[9]);   cm1[2] <= AW'(m[8]) * AW'(m[5]);
      meta1.row  <= rcnt;
      meta1.sing <= 1'b0;
      meta1.tr   <= {m[11], m[7], m[3]};
    end
  end

  // ---------------- P2: minors
  logic                 v2;
  ami_pkg::row_meta_t   meta2;
  logic signed [AW-1:0] adj2 [3], col2 [3];
  logic signed [EW-1:0] r02 [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        adj2[j] <= pp1[j] - mp1[j];
        col2[j] <= cp1[j] - cm1[j];
        r02[j]  <= r01[j];
      end
      meta2 <= meta1;
    end
  end

  // ---------------- P3: determinant partial products (32 x 32 halves)
  logic                 v3;
  ami_pkg::row_meta_t   meta3;
  logic signed [AW-1:0] adj3 [3];
  logic signed [AW-1:0] dhi3 [3];
  logic signed [AW:0]   dlo3 [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        dhi3[j] <= AW'(r02[j]) * AW'($signed(col2[j][AW-1:EW]));
        dlo3[j] <= (AW+1)'(r02[j]) * (AW+1)'($signed({1'b0, col2[j][EW-1:0]}));
        adj3[j] <= adj2[j];
      end
      meta3 <= meta2;
    end
  end

  // ---------------- P4: determinant
  logic                 v4;
  ami_pkg::row_meta_t   meta4;
  logic signed [AW-1:0] adj4 [3];
  logic signed [DW-1:0] det4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det4 <= (DW'(dhi3[0]) <<< EW) + DW'(dlo3[0])
            + (DW'(dhi3[1]) <<< EW) + DW'(dlo3[1])
            + (DW'(dhi3[2]) <<< EW) + DW'(dlo3[2]);
      for (int j = 0; j < 3; j++) adj4[j] <= adj3[j];
      meta4 <= meta3;
    end
  end

  // ---------------- P5: magnitudes and signs
  logic               v5;
  ami_pkg::row_meta_t meta5;
  logic [DW-1:0]      adet5;
  logic [AW-1:0]      aadj5 [3];
  logic               neg5 [3];

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adet5 <= det4[DW-1] ? DW'(-det4) : DW'(det4);
      for (int j = 0; j < 3; j++) begin
        aadj5[j] <= adj4[j][AW-1] ? AW'(-adj4[j]) : AW'(adj4[j]);
        neg5[j]  <= adj4[j][AW-1] != det4[DW-1];
      end
      meta5.row  <= meta4.row;
      meta5.tr   <= meta4.tr;
      meta5.sing <= (det4 == '0);
    end
  end

  // ---------------- P6 and divider: round-half-away quotient, 33 bits + overflow
  logic               dv    [QB+1];
  ami_pkg::row_meta_t dmeta [QB+1];
  logic [WN-1:0]      dden  [QB+1];
  logic [WN-1:0]      drem  [QB+1][3];
  logic [QB-1:0]      dq    [QB+1][3];
  logic               dsat  [QB+1][3];
  logic               dneg  [QB+1][3];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= v5;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dden[0]  <= WN'(adet5) << 1;
      dmeta[0] <= meta5;
      for (int j = 0; j < 3; j++) begin
        drem[0][j] <= (WN'(aadj5[j]) << (2*FRAC_BITS + 1)) + WN'(adet5);
        dsat[0][j] <= ((((WN'(aadj5[j]) << (2*FRAC_BITS + 1)) + WN'(adet5)) >> QB)
                       >= (WN'(adet5) << 1));
        dneg[0][j] <= neg5[j];
        dq[0][j]   <= '0;
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int K = QB - 1 - s;
    always_ff @(posedge clk) begin
      if (rst) dv[s+1] <= 1'b0;
      else if (adv) dv[s+1] <= dv[s];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dden[s+1]  <= dden[s];
        dmeta[s+1] <= dmeta[s];
        for (int j = 0; j < 3; j++) begin
          dsat[s+1][j] <= dsat[s][j];
          dneg[s+1][j] <= dneg[s][j];
          if ((drem[s][j] >> K) >= dden[s]) begin
            drem[s+1][j] <= drem[s][j] - (dden[s] << K);
            dq[s+1][j]   <= dq[s][j] | (QB'(1) << K);
          end else begin
            drem[s+1][j] <= drem[s][j];
            dq[s+1][j]   <= dq[s][j];
          end
        end
      end
    end
  end

  // ---------------- Q1: saturate inverse elements
  logic [QB-1:0] qv [3];
  logic          qn [3];
  logic [QB-1:0] qlim [3];
  logic [EW-1:0] qres [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qv[j]   = dq[QB][j];
      qn[j]   = dneg[QB][j] && (dsat[QB][j] || qv[j] != '0);
      qlim[j] = qn[j] ? (QB'(1) << (EW-1)) : ((QB'(1) << (EW-1)) - QB'(1));
      if (dsat[QB][j] || qv[j] > qlim[j]) qv[j] = qlim[j];
      qres[j] = qn[j] ? EW'(-qv[j]) : EW'(qv[j]);
      if (dmeta[QB].sing) qres[j] = '0;
    end
  end

  logic                 vq1;
  ami_pkg::row_meta_t   metaq1;
  logic signed [EW-1:0] inv1 [3];

  always_ff @(posedge clk) begin
    if (rst) vq1 <= 1'b0;
    else if (adv) vq1 <= dv[QB];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) inv1[j] <= $signed(qres[j]);
      metaq1 <= dmeta[QB];
    end
  end

  // ---------------- Q2: translation products
  logic                 vq2;
  ami_pkg::row_meta_t   metaq2;
  logic signed [EW-1:0] inv2 [3];
  logic signed [AW-1:0] tp2 [3];

  always_ff @(posedge clk) begin
    if (rst) vq2 <= 1'b0;
    else if (adv) vq2 <= vq1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        tp2[j]  <= AW'(inv1[j]) * AW'($signed(metaq1.tr[j]));
        inv2[j] <= inv1[j];
      end
      metaq2 <= metaq1;
    end
  end

  // ---------------- Q3: negated sum
  logic                 vq3;
  ami_pkg::row_meta_t   metaq3;
  logic signed [EW-1:0] inv3 [3];
  logic signed [CW-1:0] acc3;

  always_ff @(posedge clk) begin
    if (rst) vq3 <= 1'b0;
    else if (adv) vq3 <= vq2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc3 <= -(CW'(tp2[0]) + CW'(tp2[1]) + CW'(tp2[2]));
      for (int j = 0; j < 3; j++) inv3[j] <= inv2[j];
      metaq3 <= metaq2;
    end
  end

  // ---------------- Q4: round translation into the output register
  logic [CW-1:0] tmag, tq, tlim;
  logic          tneg;
  logic [EW-1:0] tres;
  always_comb begin
    tmag = acc3[CW-1] ? CW'(-acc3) : CW'(acc3);
    tq   = (tmag + (CW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    tneg = acc3[CW-1] && tq != '0;
    tlim = tneg ? (CW'(1) << (EW-1)) : ((CW'(1) << (EW-1)) - CW'(1));
    if (tq > tlim) tq = tlim;
    tres = tneg ? EW'(-tq) : EW'(tq);
    if (metaq3.sing) tres = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vq3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_index <= metaq3.row;
      c0        <= inv3[0];
      c1        <= inv3[1];
      c2        <= inv3[2];
      c3        <= $signed(tres);
      singular  <= metaq3.sing;
      last_row  <= (metaq3.row == ami_pkg::ROW_LAST);
    end
  end

  // ---------------- checks
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> c0 == 0 && c1 == 0 && c2 == 0 && c3 == 0)
    else $error("singular row carries non-zero elements");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_row == (row_index == ami_pkg::ROW_LAST))
    else $error("last_row disagrees with row_index");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_index != 2'd3)
    else $error("row_index out of range");

  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> busy && rcnt == 2'd0)
    else $error("accepted matrix not held for issue");

endmodule
